[rtl/sbsp_pkg.sv]
// Package with types, constants and helpers for the servo bus status poller.
package sbsp_pkg;

  localparam int CFG_W = 40;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SERVO_IDS      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GOAL_POSITIONS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TORQUE_LIMITS  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLY_TIMEOUT  = 3'd4;

  localparam logic [31:0] SERVO_IDS_RESET      = 32'd17694726;
  localparam logic [39:0] GOAL_POSITIONS_RESET = 40'd473983404850;
  localparam logic [39:0] TORQUE_LIMITS_RESET  = 40'd549218418175;
  localparam logic [15:0] POLL_INTERVAL_RESET  = 16'd2500;
  localparam logic [7:0]  REPLY_TIMEOUT_RESET  = 8'd20;

  localparam logic [7:0] HEADER_BYTE     = 8'hFF;
  localparam logic [7:0] INSTR_READ      = 8'h02;
  localparam logic [7:0] INSTR_WRITE     = 8'h03;
  localparam logic [7:0] LEN_BYTE_WRITE  = 8'h04;
  localparam logic [7:0] LEN_WORD_WRITE  = 8'h05;
  localparam logic [7:0] LEN_READ        = 8'h04;
  localparam logic [7:0] ADDR_TORQUE_EN  = 8'd24;
  localparam logic [7:0] ADDR_TORQUE_LIM = 8'd34;
  localparam logic [7:0] ADDR_GOAL_POS   = 8'd30;
  localparam logic [7:0] ADDR_STATUS     = 8'd40;
  localparam logic [7:0] TORQUE_ON       = 8'd1;
  localparam logic [7:0] STATUS_LEN      = 8'd4;

  localparam int REPLY_LEN = 10;
  localparam int BURST_LEN = 34;
  localparam int BURST_IDX_W = 6;
  localparam logic [BURST_IDX_W-1:0] BURST_LAST = 6'(BURST_LEN - 1);

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam int CMD_DEPTH = 4;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] tx_byte;
    logic [7:0] servo_id;
    logic [7:0] temperature;
    logic [9:0] load_magnitude;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] id;
    logic [9:0] torque;
    logic [9:0] goal;
    logic [7:0] temperature;
    logic [9:0] load;
  } cmd_t;

  function automatic logic [7:0] slot_id(input logic [31:0] ids, input logic [2:0] s);
    logic [7:0] r;
    case (s)
      3'd0: r = ids[7:0];
      3'd1: r = ids[15:8];
      3'd2: r = ids[23:16];
      3'd3: r = ids[31:24];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] slot_word(input logic [39:0] p, input logic [2:0] s);
    logic [9:0] r;
    case (s)
      3'd0: r = p[9:0];
      3'd1: r = p[19:10];
      3'd2: r = p[29:20];
      3'd3: r = p[39:30];
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] burst_byte(input logic [BURST_IDX_W-1:0] idx,
                                            input logic [7:0] id,
                                            input logic [9:0] tl,
                                            input logic [9:0] gp);
    logic [7:0] tl_lo;
    logic [7:0] tl_hi;
    logic [7:0] gp_lo;
    logic [7:0] gp_hi;
    logic [7:0] r;
    tl_lo = tl[7:0];
    tl_hi = {6'd0, tl[9:8]};
    gp_lo = gp[7:0];
    gp_hi = {6'd0, gp[9:8]};
    case (idx) inside
      6'd0, 6'd1, 6'd8, 6'd9, 6'd17, 6'd18, 6'd26, 6'd27: r = HEADER_BYTE;
      6'd2, 6'd10, 6'd19, 6'd28: r = id;
      6'd3: r = LEN_BYTE_WRITE;
      6'd11, 6'd20: r = LEN_WORD_WRITE;
      6'd29: r = LEN_READ;
      6'd4, 6'd12, 6'd21: r = INSTR_WRITE;
      6'd30: r = INSTR_READ;
      6'd5: r = ADDR_TORQUE_EN;
      6'd6: r = TORQUE_ON;
      6'd7: r = ~(id + LEN_BYTE_WRITE + INSTR_WRITE + ADDR_TORQUE_EN + TORQUE_ON);
      6'd13: r = ADDR_TORQUE_LIM;
      6'd14: r = tl_lo;
      6'd15: r = tl_hi;
      6'd16: r = ~(id + LEN_WORD_WRITE + INSTR_WRITE + ADDR_TORQUE_LIM + tl_lo + tl_hi);
      6'd22: r = ADDR_GOAL_POS;
      6'd23: r = gp_lo;
      6'd24: r = gp_hi;
      6'd25: r = ~(id + LEN_WORD_WRITE + INSTR_WRITE + ADDR_GOAL_POS + gp_lo + gp_hi);
      6'd31: r = ADDR_STATUS;
      6'd32: r = STATUS_LEN;
      6'd33: r = ~(id + LEN_READ + INSTR_READ + ADDR_STATUS + STATUS_LEN);
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/sbsp_front.sv]
// Front end: configuration registers, poll scheduling, echo skipping and reply checking.
module sbsp_front #(
  parameter int NUM_SERVOS = 4,
  parameter int ECHO_BYTES = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  sbsp_pkg::item_t                 item,
  input  logic                            cfg_write,
  input  logic [sbsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbsp_pkg::CFG_W-1:0]       cfg_data,
  output logic                            cmd_valid,
  output sbsp_pkg::cmd_t                  cmd
);
  import sbsp_pkg::*;

  localparam int SLOT_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int RXC_W = $clog2(ECHO_BYTES + REPLY_LEN);
  localparam int STORE_LEN = REPLY_LEN - 1;

  logic [31:0] servo_ids;
  logic [39:0] goal_positions;
  logic [39:0] torque_limits;
  logic [15:0] poll_interval;
  logic [7:0]  reply_timeout;

  logic              waiting;
  logic [SLOT_W-1:0] slot;
  logic [15:0]       idle_elapsed;
  logic [7:0]        wait_elapsed;
  logic [RXC_W-1:0]  rx_count;
  logic [7:0]        reply [STORE_LEN];

  logic [15:0]      idle_next;
  logic             fire;
  logic             timed_out;
  logic             store_en;
  logic [RXC_W-1:0] reply_pos;
  logic             reply_done;
  logic             reply_match;
  logic [7:0]       cur_id;
  logic             finish;
  logic [SLOT_W-1:0] slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_ids <= SERVO_IDS_RESET;
      goal_positions <= GOAL_POSITIONS_RESET;
      torque_limits <= TORQUE_LIMITS_RESET;
      poll_interval <= POLL_INTERVAL_RESET;
      reply_timeout <= REPLY_TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SERVO_IDS:      servo_ids <= cfg_data[31:0];
        REG_GOAL_POSITIONS: goal_positions <= cfg_data;
        REG_TORQUE_LIMITS:  torque_limits <= cfg_data;
        REG_POLL_INTERVAL:  poll_interval <= cfg_data[15:0];
        REG_REPLY_TIMEOUT:  reply_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cur_id = slot_id(servo_ids, 3'(slot));
  assign idle_next = (idle_elapsed != 16'hFFFF) ? idle_elapsed + 16'd1 : idle_elapsed;
  assign fire = accept && !waiting && (item.func == FUNC_TICK) && (idle_next >= poll_interval);
  assign timed_out = accept && waiting && (item.func == FUNC_TICK) &&
                     (wait_elapsed >= reply_timeout);
  assign reply_pos = rx_count - RXC_W'(ECHO_BYTES);
  assign store_en = accept && waiting && (item.func == FUNC_BYTE) &&
                    (rx_count >= RXC_W'(ECHO_BYTES)) &&
                    (rx_count < RXC_W'(ECHO_BYTES + STORE_LEN));
  assign reply_done = accept && waiting && (item.func == FUNC_BYTE) &&
                      (rx_count == RXC_W'(ECHO_BYTES + REPLY_LEN - 1));
  assign reply_match = (reply[0] == HEADER_BYTE) && (reply[1] == HEADER_BYTE) &&
                       (reply[2] == cur_id);
  assign finish = timed_out || reply_done;
  assign slot_next = (slot == SLOT_W'(NUM_SERVOS - 1)) ? '0 : slot + 1'b1;

  always_ff @(posedge clk) begin
    if (store_en) begin
      reply[reply_pos[3:0]] <= item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting <= 1'b0;
      slot <= '0;
      idle_elapsed <= '0;
      wait_elapsed <= '0;
      rx_count <= '0;
    end else if (accept) begin
      if (!waiting) begin
        if (item.func == FUNC_TICK) begin
          idle_elapsed <= idle_next;
          if (fire) begin
            waiting <= 1'b1;
            wait_elapsed <= '0;
            rx_count <= '0;
          end
        end
      end else if (finish) begin
        waiting <= 1'b0;
        slot <= slot_next;
        idle_elapsed <= '0;
      end else if (item.func == FUNC_TICK) begin
        wait_elapsed <= wait_elapsed + 8'd1;
      end else begin
        rx_count <= rx_count + 1'b1;
      end
    end
  end

  always_comb begin
    cmd_valid = fire || (reply_done && reply_match);
    cmd.kind = fire ? KIND_TX : KIND_REPORT;
    cmd.id = cur_id;
    cmd.torque = slot_word(torque_limits, 3'(slot));
    cmd.goal = slot_word(goal_positions, 3'(slot));
    cmd.temperature = reply[8];
    cmd.load = {reply[6][1:0], reply[5]};
  end

endmodule

[rtl/sbsp_cmd_fifo.sv]
// Short command queue between the front end and the output sequencer.
module sbsp_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  sbsp_pkg::cmd_t wr_cmd,
  input  logic           rd,
  output logic           full,
  output logic           valid,
  output sbsp_pkg::cmd_t head
);
  import sbsp_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             entries [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(CMD_DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(CMD_DEPTH))
    else $error("command queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) rd |-> count != '0)
    else $error("command queue read while empty");

endmodule

[rtl/sbsp_back.sv]
// Output sequencer: expands burst commands into bytes and holds the result register.
module sbsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  sbsp_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output sbsp_pkg::result_t result
);
  import sbsp_pkg::*;

  logic                   out_valid;
  logic [BURST_IDX_W-1:0] idx;
  logic                   load;
  logic                   burst_end;

  assign load = cmd_valid && (!out_valid || pop);
  assign burst_end = (idx == BURST_LAST);
  assign cmd_pop = load && ((cmd.kind == KIND_REPORT) || burst_end);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load && (cmd.kind == KIND_TX)) begin
        idx <= burst_end ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cmd.kind == KIND_REPORT) begin
        result.out_kind <= KIND_REPORT;
        result.tx_byte <= 8'd0;
        result.servo_id <= cmd.id;
        result.temperature <= cmd.temperature;
        result.load_magnitude <= cmd.load;
        result.last <= 1'b1;
      end else begin
        result.out_kind <= KIND_TX;
        result.tx_byte <= burst_byte(idx, cmd.id, cmd.torque, cmd.goal);
        result.servo_id <= 8'd0;
        result.temperature <= 8'd0;
        result.load_magnitude <= 10'd0;
        result.last <= burst_end;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) idx <= BURST_LAST)
    else $error("burst index out of range");
  assert property (@(posedge clk) disable iff (rst) cmd_pop |=> !empty && result.last)
    else $error("finished command did not leave a final word");

endmodule

[rtl/servo_bus_status_poller.sv]
// Top level of the round-robin servo bus status poller.
// The input channel takes one word per millisecond tick (func 0) or per received bus
// byte (func 1); a word is taken on a clock edge with push high and full low.
// The result channel presents the oldest result while empty is low; pop takes it.
// A result is either a byte to transmit or a status report for one servo; last marks
// the final byte of a 34-byte transmit burst and every report.
// Configuration registers are written through cfg_write, cfg_index and cfg_data and
// must only change while no poll is in flight.
// Each input word is handled by the front end, which pushes at most one command into
// a four-entry queue. The sequencer emits one result word per cycle while commands
// are queued and pop keeps taking results. With the sequencer free, the first byte of
// a burst passes from the command queue into the result register after the edge that
// accepts its tick, and a report does so after the edge that accepts the last reply byte.
// Input words are taken every cycle while the command queue has room; full rises only
// when four commands are queued, which happens when the result side stalls or when
// polls start faster than the sequencer drains their 34-byte bursts.
// A stalled pop holds the current result and lets the queue fill behind it.
// Synchronous reset returns the configuration registers to their defaults, empties the queue and puts
// the poller in the idle phase at slot 0.
module servo_bus_status_poller #(
  parameter int NUM_SERVOS = 4,
  parameter int ECHO_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  sbsp_pkg::item_t                  item,
  output logic                             empty,
  input  logic                             pop,
  output sbsp_pkg::result_t                result,
  input  logic                             cfg_write,
  input  logic [sbsp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbsp_pkg::CFG_W-1:0]       cfg_data
);
  import sbsp_pkg::*;

  logic accept;
  logic fc_valid;
  cmd_t fc_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  assign accept = push && !full;

  sbsp_front #(
    .NUM_SERVOS(NUM_SERVOS),
    .ECHO_BYTES(ECHO_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .item(item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(fc_valid),
    .cmd(fc_cmd)
  );

  sbsp_cmd_fifo u_queue (
    .clk(clk),
    .rst(rst),
    .wr(fc_valid),
    .wr_cmd(fc_cmd),
    .rd(q_pop),
    .full(full),
    .valid(q_valid),
    .head(q_head)
  );

  sbsp_back u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(q_valid),
    .cmd(q_head),
    .cmd_pop(q_pop),
    .pop(pop),
    .empty(empty),
    .result(result)
  );

endmodule
